// File: rtl/lpct_pkg.sv
// Package for the linear probing count table.
// Holds the default table size, the hash multiplier, op codes, the slot record and FSM states.
// No dependencies.
package lpct_pkg;

  localparam int unsigned SLOTS_DEF = 4096;
  localparam logic [31:0] HASH_MUL  = 32'h045d_9f3b;

  // Item op codes.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] count;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CHECK
  } state_t;

endpackage

// File: rtl/lpct_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the slot store of the count table.
module lpct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/linear_probe_count_table_top.sv
// Linear probing count table: lookup, saturating add and clear on a slot RAM.
// Lookup/add: hash, then for non-power-of-two SLOTS a modulo step (quotient estimate, then
// remainder), then one RAM read and one check per probe; the result is registered as the block
// returns to idle, and the next item is taken once idle. Clear sweeps the RAM one slot a cycle.
// The probe loop of one RAM read and one check per slot sets the rate; results are never held.
// Reset: synchronous; a sweep empties the table with busy high.
module linear_probe_count_table_top import lpct_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_delta,
  output logic               out_valid,
  output logic signed [31:0] out_count_value,
  output logic               out_found,
  output logic               out_table_full
);

  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam bit          IS_POW2  = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W:0]   SLOTS_W  = (IDX_W + 1)'(SLOTS);
  localparam logic [31:0]      RECIP    = 32'(64'hffff_ffff / 64'(SLOTS));

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [31:0]      delta_r, delta_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic [31:0]      quot_r, quot_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic             rpt_r, rpt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_count_r, out_count_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_full_r, out_full_nxt;

  logic             accept;
  logic [31:0]      mix;
  logic [31:0]      product;
  logic [63:0]      recip_prod;
  logic [IDX_W:0]   quot_s;
  logic [IDX_W:0]   mod_diff;
  logic [IDX_W-1:0] mod_rem;
  logic [IDX_W-1:0] idx_inc;
  slot_t            rd_slot;
  slot_t            wr_slot;
  logic [SLOT_W-1:0] ram_rdata;
  logic             ram_we;
  logic             ram_re;
  logic             is_empty;
  logic             is_hit;
  logic             is_last;
  logic [32:0]      sum;
  logic [31:0]      sat;

  assign accept = start && (state_r == ST_IDLE);

  // Hash: fold the upper half down, then one 32-bit multiply.
  assign mix     = key_r ^ {16'd0, key_r[31:16]};
  assign product = mix * HASH_MUL;

  // Modulo by SLOTS in two steps: a quotient estimate from the reciprocal, which is exact
  // or one short, then the remainder with one conditional subtract.
  assign recip_prod = 64'(hash_r) * 64'(RECIP);
  assign quot_s     = quot_r[IDX_W:0] * SLOTS_W;
  assign mod_diff   = hash_r[IDX_W:0] - quot_s;
  assign mod_rem    = (mod_diff >= SLOTS_W) ? IDX_W'(mod_diff - SLOTS_W) :
                                              mod_diff[IDX_W-1:0];

  assign idx_inc = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  // Slot check and saturating add.
  assign rd_slot  = slot_t'(ram_rdata);
  assign is_empty = !rd_slot.valid;
  assign is_hit   = rd_slot.valid && (rd_slot.key == key_r);
  assign is_last  = (n_r == LAST_IDX);
  assign sum      = {rd_slot.count[31], rd_slot.count} + {delta_r[31], delta_r};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_HASH;
      end
      ST_HASH: begin
        if (op_r == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (op_r == OP_NONE) begin
          state_nxt = ST_IDLE;
        end else if (IS_POW2) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (bit_r == 5'd0) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (is_empty || is_hit || is_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result values.
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    delta_nxt     = delta_r;
    hash_nxt      = hash_r;
    quot_nxt      = quot_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    rpt_nxt       = rpt_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wr_slot       = '0;
    case (state_r)
      ST_CLEAR: begin
        // Empty one slot a cycle; a clear op reports when the sweep ends.
        ram_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == LAST_IDX) begin
          out_valid_nxt = rpt_r;
          out_count_nxt = '0;
          out_found_nxt = 1'b0;
          out_full_nxt  = 1'b0;
          rpt_nxt       = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = op_t'(in_op);
          key_nxt   = in_key;
          delta_nxt = in_delta;
        end
      end
      ST_HASH: begin
        n_nxt    = '0;
        hash_nxt = product;
        bit_nxt  = 5'd1;
        if (op_r == OP_CLEAR) begin
          idx_nxt = '0;
          rpt_nxt = 1'b1;
        end else if (op_r == OP_NONE) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
          out_found_nxt = 1'b0;
          out_full_nxt  = 1'b0;
        end else if (IS_POW2) begin
          idx_nxt = product[IDX_W-1:0];
        end else begin
          idx_nxt = '0;
        end
      end
      ST_MOD: begin
        // First the quotient estimate is taken, then the remainder as home slot.
        if (bit_r != 5'd0) begin
          quot_nxt = recip_prod[63:32];
          bit_nxt  = bit_r - 5'd1;
        end else begin
          idx_nxt = mod_rem;
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_CHECK: begin
        wr_slot.valid = 1'b1;
        wr_slot.key   = key_r;
        out_count_nxt = '0;
        out_found_nxt = 1'b0;
        out_full_nxt  = 1'b0;
        if (is_hit) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          if (op_r == OP_ADD) begin
            ram_we        = 1'b1;
            wr_slot.count = sat;
            out_count_nxt = sat;
          end else begin
            out_count_nxt = rd_slot.count;
          end
        end else if (is_empty) begin
          out_valid_nxt = 1'b1;
          if (op_r == OP_ADD) begin
            ram_we        = 1'b1;
            wr_slot.count = delta_r;
            out_count_nxt = delta_r;
          end
        end else if (is_last) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = (op_r == OP_ADD);
        end else begin
          idx_nxt = idx_inc;
          n_nxt   = n_r + 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      rpt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rpt_r       <= rpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    delta_r     <= delta_nxt;
    hash_r      <= hash_nxt;
    quot_r      <= quot_nxt;
    bit_r       <= bit_nxt;
    n_r         <= n_nxt;
    out_count_r <= out_count_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Slot store. Reads and writes of one item fall in different states, and items run one
  // at a time, so no two accesses to a slot overlap.
  lpct_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r),
    .wr_data (wr_slot),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_count_value = out_count_r;
  assign out_found       = out_found_r;
  assign out_table_full  = out_full_r;

endmodule

// File: rtl/lpct_checker.sv
// Port-level checks for the linear probing count table.
// Depends on linear_probe_count_table_top; attached to it by the bind at the end.
module lpct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_count_value,
  input logic               out_found,
  input logic               out_table_full
);

  // A result only shows once the item is done.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted item occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // One strobe per item.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted two cycles");

  // A full table means no slot was found and no count is reported.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (!out_found && (out_count_value == 32'sd0)))
    else $error("full flag with a found key or nonzero count");

endmodule

bind linear_probe_count_table_top lpct_checker u_lpct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_count_value (out_count_value),
  .out_found       (out_found),
  .out_table_full  (out_table_full)
);

// File: tb/sv/tb_top.sv
// Testbench for linear_probe_count_table_top: lookups, saturating adds and clears
// checked against a predictor of the slot table. Depends on lpct_pkg and the top module.
module tb_top;
  import lpct_pkg::*;

  localparam int unsigned TB_SLOTS       = SLOTS_DEF;
  // Longest quiet stretch: the reset sweep, or a full-table probe plus the sender's gap.
  localparam int unsigned WATCHDOG_LIMIT = 8 * TB_SLOTS + 4096;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned POOL_SIZE      = 48;

  typedef struct packed {
    logic [31:0] count;
    logic        found;
    logic        full;
  } tally_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic signed [31:0] in_key;
  logic signed [31:0] in_delta;
  logic               out_valid;
  logic signed [31:0] out_count_value;
  logic               out_found;
  logic               out_table_full;

  // Shadow copy of the slot table.
  bit [TB_SLOTS-1:0] slot_used;
  logic [31:0]       slot_keys [TB_SLOTS];
  logic [31:0]       slot_tally [TB_SLOTS];

  tally_t      pending_tallies [$];
  int unsigned bad_results = 0;
  int unsigned idle_cycles = 0;
  bit          steady_sender = 1'b0;

  linear_probe_count_table_top #(.SLOTS(TB_SLOTS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_delta        (in_delta),
    .out_valid       (out_valid),
    .out_count_value (out_count_value),
    .out_found       (out_found),
    .out_table_full  (out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Home slot of a key: mixed hash reduced modulo the table size.
  function automatic int unsigned home_slot_of(logic [31:0] k);
    logic [31:0] h;
    h = (k ^ (k >> 16)) * HASH_MUL;
    return h % TB_SLOTS;
  endfunction

  // Walk the probe path; returns 0 when every slot was visited without a stop.
  function automatic bit probe_path(input logic [31:0] k, output int unsigned idx,
                                    output bit hit);
    int unsigned b;
    b   = home_slot_of(k);
    idx = 0;
    hit = 1'b0;
    for (int unsigned n = 0; n < TB_SLOTS; n++) begin
      if (!slot_used[b]) begin
        idx = b;
        return 1'b1;
      end
      if (slot_keys[b] == k) begin
        idx = b;
        hit = 1'b1;
        return 1'b1;
      end
      b = (b + 1 == TB_SLOTS) ? 0 : b + 1;
    end
    return 1'b0;
  endfunction

  // Apply one item to the shadow table and return the tally the block must report.
  function automatic tally_t table_apply(op_t op, logic [31:0] k, logic [31:0] d);
    tally_t      r;
    int unsigned idx;
    bit          hit;
    longint      sum;
    r = '0;
    case (op)
      OP_LOOKUP: begin
        if (probe_path(k, idx, hit) && hit) begin
          r.count = slot_tally[idx];
          r.found = 1'b1;
        end
      end
      OP_ADD: begin
        if (!probe_path(k, idx, hit)) begin
          r.full = 1'b1;
        end else if (hit) begin
          sum = longint'($signed(slot_tally[idx])) + longint'($signed(d));
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          slot_tally[idx] = sum[31:0];
          r.count = sum[31:0];
          r.found = 1'b1;
        end else begin
          slot_used[idx]  = 1'b1;
          slot_keys[idx]  = k;
          slot_tally[idx] = d;
          r.count = d;
        end
      end
      OP_CLEAR: slot_used = '0;
      default: ;
    endcase
    return r;
  endfunction

  // Drive one item from the falling edge and hold it until the block takes it.
  task automatic send_item(input op_t op, input logic [31:0] key, input logic [31:0] delta);
    int unsigned gap;
    gap = steady_sender ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_delta <= delta;
    do @(posedge clk); while (busy !== 1'b0);
    pending_tallies.push_back(table_apply(op, key, delta));
  endtask

  // Compare each result with the oldest outstanding tally.
  always @(posedge clk) begin : check_results
    tally_t want;
    if (rst_n && out_valid) begin
      if (pending_tallies.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: count=%0d found=%0b full=%0b",
                   out_count_value, out_found, out_table_full);
      end else begin
        want = pending_tallies.pop_front();
        if (want.count !== out_count_value || want.found !== out_found ||
            want.full !== out_table_full) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: exp count=%0d found=%0b full=%0b, got %0d %0b %0b",
                     $signed(want.count), want.found, want.full,
                     out_count_value, out_found, out_table_full);
        end
      end
    end
  end

  // Stop a hung run: too many cycles with no item taken and no result seen.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Lookups right after reset must miss.
  task automatic test_empty_table();
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff);
  endtask

  // Counts clamp at both ends of the signed range.
  task automatic test_saturation();
    send_item(OP_ADD, 32'd5, 32'h7fff_ffff);
    send_item(OP_ADD, 32'd5, 32'd1);
    send_item(OP_ADD, 32'd5, 32'h8000_0000);
    send_item(OP_ADD, 32'hffff_fffb, 32'h8000_0000);
    send_item(OP_ADD, 32'hffff_fffb, 32'hffff_ffff);
    send_item(OP_LOOKUP, 32'd5, 32'd0);
    send_item(OP_LOOKUP, 32'hffff_fffb, 32'd0);
  endtask

  // The most negative key, a count that returns to zero, the unused op and clear.
  task automatic test_special_cases();
    send_item(OP_ADD, 32'h8000_0000, 32'd3);
    send_item(OP_LOOKUP, 32'h8000_0000, 32'd0);
    send_item(OP_ADD, 32'h7fff_ffff, 32'hffff_fffd);
    send_item(OP_ADD, 32'h7fff_ffff, 32'd3);
    send_item(OP_LOOKUP, 32'h7fff_ffff, 32'd0);
    send_item(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_LOOKUP, 32'd5, 32'd0);
    send_item(OP_LOOKUP, 32'h8000_0000, 32'd0);
  endtask

  // Three keys that share the last home slot, so probing wraps to slot zero.
  task automatic test_probe_wrap();
    logic [31:0] wrap_keys [3];
    logic [31:0] k;
    for (int i = 0; i < 3; i++) begin
      do k = $urandom(); while (home_slot_of(k) != TB_SLOTS - 1);
      wrap_keys[i] = k;
    end
    for (int i = 0; i < 3; i++) send_item(OP_ADD, wrap_keys[i], 32'd10 + i);
    send_item(OP_LOOKUP, wrap_keys[2], 32'd0);
    send_item(OP_ADD, wrap_keys[1], 32'hffff_fff0);
    send_item(OP_LOOKUP, wrap_keys[1], 32'd0);
  endtask

  // Mostly adds and lookups on a small key pool, so keys recur and counts build up.
  task automatic test_random_mix();
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] key;
    logic [31:0] delta;
    op_t         op;
    int unsigned pick;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) steady_sender = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 48)      op = OP_ADD;
      else if (pick < 96) op = OP_LOOKUP;
      else if (pick < 98) op = OP_CLEAR;
      else                op = OP_NONE;
      key = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 50)      delta = $urandom_range(0, 200) - 100;
      else if (pick < 70) delta = $urandom();
      else if (pick < 85) delta = 32'h7000_0000 + $urandom_range(0, 32'h0fff_ffff);
      else                delta = 32'h8000_0000 + $urandom_range(0, 32'h0fff_ffff);
      send_item(op, key, delta);
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_op    = OP_LOOKUP;
    in_key   = '0;
    in_delta = '0;
    slot_used = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_saturation();
    test_special_cases();
    test_probe_wrap();
    test_random_mix();

    // Let the last results come back before deciding.
    @(negedge clk);
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
